>>> sv/nntp_pkg.sv
// Shared types, codes and helpers for the note name text parser.
// Used by every module of the block; depends on nothing.
package nntp_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_DIGITS = 3'd1,
		PH_LETTER = 3'd2,
		PH_ACC    = 3'd3,
		PH_MINUS  = 3'd4,
		PH_OCTAVE = 3'd5
	} phase_t;

	// Result error codes
	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_EMPTY      = 3'd1,
		ERR_NUM_RANGE  = 3'd2,
		ERR_NO_LETTER  = 3'd3,
		ERR_NO_OCTAVE  = 3'd4,
		ERR_TRAILING   = 3'd5,
		ERR_NOTE_RANGE = 3'd6
	} err_t;

	// Accidental codes
	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_SHARP = 2'd1;
	localparam logic [1:0] ACC_FLAT  = 2'd2;

	// Character codes
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_LOW_B = 8'd98;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam logic [4:0]  MCO_RESET       = 5'd3;

	// Parse state captured at the end of one text
	typedef struct packed {
		phase_t     phase;
		logic [3:0] pitch;
		logic [1:0] accidental;
		logic       octave_neg;
		logic [7:0] accum;
		err_t       sticky;
	} snap_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	// Pitch plus one for a note letter, zero for anything else
	function automatic logic [3:0] letter_pitch(input logic [7:0] c);
		logic [7:0] u;
		logic [3:0] p;
		u = ((c >= 8'd97) && (c <= 8'd122)) ? c - 8'd32 : c;
		unique case (u)
			8'd67:   p = 4'd1;
			8'd68:   p = 4'd3;
			8'd69:   p = 4'd5;
			8'd70:   p = 4'd6;
			8'd71:   p = 4'd8;
			8'd65:   p = 4'd10;
			8'd66:   p = 4'd12;
			default: p = 4'd0;
		endcase
		return p;
	endfunction

	// acc*10 + digit, saturating at 255
	function automatic logic [7:0] push_digit(input logic [7:0] acc, input logic [7:0] c);
		logic [11:0] v;
		v = 12'({acc, 3'b000}) + 12'({acc, 1'b0}) + 12'(c[3:0]);
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

>>> sv/nntp_front.sv
// Front end: accepts characters, classifies them and advances the parse state.
// Hands a snapshot of the finished parse to the queue. Depends on nntp_pkg.
module nntp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    text_char,
	input  logic          char_present,
	input  logic          end_of_text,
	output logic          push,
	output nntp_pkg::snap_t push_snap
);
	import nntp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] pitch_q, pitch_d;
	logic [1:0] accid_q, accid_d;
	logic       neg_q, neg_d;
	logic [7:0] accum_q, accum_d;
	logic       pend_q, pend_d;
	err_t       sticky_q, sticky_d;
	logic [3:0] lp;
	logic       dig;

	// Character classification
	assign lp  = letter_pitch(text_char);
	assign dig = is_digit(text_char);

	// Next parse state for the current character
	always_comb begin
		phase_d  = phase_q;
		pitch_d  = pitch_q;
		accid_d  = accid_q;
		neg_d    = neg_q;
		accum_d  = accum_q;
		pend_d   = pend_q;
		sticky_d = sticky_q;
		if (char_present && (sticky_q == ERR_OK)) begin
			if (is_space(text_char)) begin
				if (phase_q != PH_START) pend_d = 1'b1;
			end else if (pend_q) begin
				sticky_d = (phase_q == PH_DIGITS) ? ERR_NO_LETTER : ERR_TRAILING;
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (dig) begin
							phase_d = PH_DIGITS;
							accum_d = push_digit(accum_q, text_char);
						end else if (lp == 4'd0) begin
							sticky_d = ERR_NO_LETTER;
						end else begin
							pitch_d = lp - 4'd1;
							phase_d = PH_LETTER;
						end
					end
					PH_DIGITS: begin
						if (dig) accum_d = push_digit(accum_q, text_char);
						else sticky_d = ERR_NO_LETTER;
					end
					PH_LETTER, PH_ACC, PH_MINUS, PH_OCTAVE: begin
						if ((phase_q == PH_LETTER) && (text_char == CH_HASH)) begin
							accid_d = ACC_SHARP;
							phase_d = PH_ACC;
						end else if ((phase_q == PH_LETTER) && (text_char == CH_LOW_B)) begin
							accid_d = ACC_FLAT;
							phase_d = PH_ACC;
						end else if (((phase_q == PH_LETTER) || (phase_q == PH_ACC))
								&& (text_char == CH_MINUS)) begin
							neg_d   = 1'b1;
							phase_d = PH_MINUS;
						end else if (dig) begin
							accum_d = push_digit(accum_q, text_char);
							phase_d = PH_OCTAVE;
						end else begin
							sticky_d = ERR_TRAILING;
						end
					end
					default: sticky_d = ERR_TRAILING;
				endcase
			end
		end
	end

	// Snapshot goes to the queue on the last item
	assign push = accept && end_of_text;
	always_comb begin
		push_snap.phase      = phase_d;
		push_snap.pitch      = pitch_d;
		push_snap.accidental = accid_d;
		push_snap.octave_neg = neg_d;
		push_snap.accum      = accum_d;
		push_snap.sticky     = sticky_d;
	end

	// Parse state registers; cleared after each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			pitch_q  <= 4'd0;
			accid_q  <= ACC_NONE;
			neg_q    <= 1'b0;
			accum_q  <= 8'd0;
			pend_q   <= 1'b0;
			sticky_q <= ERR_OK;
		end else if (accept) begin
			if (end_of_text) begin
				phase_q  <= PH_START;
				pitch_q  <= 4'd0;
				accid_q  <= ACC_NONE;
				neg_q    <= 1'b0;
				accum_q  <= 8'd0;
				pend_q   <= 1'b0;
				sticky_q <= ERR_OK;
			end else begin
				phase_q  <= phase_d;
				pitch_q  <= pitch_d;
				accid_q  <= accid_d;
				neg_q    <= neg_d;
				accum_q  <= accum_d;
				pend_q   <= pend_d;
				sticky_q <= sticky_d;
			end
		end
	end

	// First error wins until the text ends
	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_OK) && !(accept && end_of_text) |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed inside a text");

	// Pending whitespace only after something was seen
	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q != PH_START))
		else $error("pending space in start phase");

endmodule

>>> sv/nntp_queue.sv
// Short queue of parse snapshots between front and back ends.
// Depends on nntp_pkg for the snapshot type.
module nntp_queue #(
	parameter int unsigned DEPTH = nntp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nntp_pkg::snap_t push_snap,
	input  logic            pop,
	output logic            not_empty,
	output logic            full,
	output nntp_pkg::snap_t head
);
	import nntp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	snap_t             slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head      = slot_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_snap;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

>>> sv/nntp_back.sv
// Back end: resolves a queued parse snapshot into note number and error code.
// Holds the octave offset register and the output register. Depends on nntp_pkg.
module nntp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	input  logic            snap_valid,
	input  nntp_pkg::snap_t snap,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata
);
	import nntp_pkg::*;

	logic [4:0]         mco_q;
	logic signed [9:0]  oct;
	logic signed [10:0] base;
	logic signed [14:0] adj;
	logic signed [14:0] note_full;
	logic [6:0]         note_d;
	err_t               err_d;
	logic               valid_q;
	logic [6:0]         note_q;
	err_t               err_q;

	// Middle C octave register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mco_q <= MCO_RESET;
		else if (cfg_we) mco_q <= cfg_wdata;
	end

	// (octave + 5 - mco) * 12 + pitch + accidental
	always_comb begin
		oct  = snap.octave_neg ? -$signed({2'b00, snap.accum}) : $signed({2'b00, snap.accum});
		base = 11'(oct) + 11'sd5 - 11'($signed(mco_q));
		case (snap.accidental)
			ACC_SHARP: adj = 15'sd1;
			ACC_FLAT:  adj = -15'sd1;
			default:   adj = 15'sd0;
		endcase
		note_full = (15'(base) <<< 3) + (15'(base) <<< 2)
			+ $signed({11'd0, snap.pitch}) + adj;
	end

	// Result selection
	always_comb begin
		note_d = 7'd0;
		err_d  = ERR_OK;
		if (snap.sticky != ERR_OK) begin
			err_d = snap.sticky;
		end else begin
			unique case (snap.phase)
				PH_START: err_d = ERR_EMPTY;
				PH_DIGITS: begin
					if (snap.accum > 8'd127) err_d = ERR_NUM_RANGE;
					else note_d = snap.accum[6:0];
				end
				PH_OCTAVE: begin
					if (note_full[14] || (note_full > 15'sd127)) err_d = ERR_NOTE_RANGE;
					else note_d = note_full[6:0];
				end
				default: err_d = ERR_NO_OCTAVE;
			endcase
		end
	end

	// Output register; refills while the old request is being taken
	assign pop = snap_valid && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			note_q <= note_d;
			err_q  <= err_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, err_q, note_q};

	a_err_zero_note: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (err_q != ERR_OK) |-> note_q == 7'd0)
		else $error("note nonzero with error");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop && valid_q |-> m_tready)
		else $error("output overwritten while stalled");

endmodule

>>> sv/note_name_text_parser_core.sv
// Note name text parser, top level: front end, snapshot queue, back end.
// Depends on nntp_pkg, nntp_front, nntp_queue, nntp_back.
//
// Input channel s_*: one character per request. s_tdata = text_char,
// s_tuser = char_present (0: the request only ends the text), s_tlast =
// end_of_text. Only the last request of a text gives a result.
// Output channel m_*: m_tdata[6:0] = note_number, m_tdata[9:7] = error_code.
// Config: cfg_we writes cfg_wdata (signed middle C octave); write only idle.
// Throughput: one character per cycle while s_tready is high. The front end
// updates the parse state in the accepting cycle; a finished text enters a
// QUEUE_DEPTH-entry queue, and the back end resolves the note into the
// output register. When the receiver stalls, the output register holds
// its result and up to QUEUE_DEPTH more finished texts wait in the queue;
// s_tready falls only when the queue is full. Reset clears the parse state,
// empties the queue and output, and sets middle C octave to 3.
module note_name_text_parser_core #(
	parameter int unsigned QUEUE_DEPTH = nntp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // middle_c_octave
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // text_char
	input  logic        s_tuser,     // char_present
	input  logic        s_tlast,     // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // note_number[6:0], error_code[9:7], zero fill
);
	import nntp_pkg::*;

	logic  accept;
	logic  push;
	snap_t push_snap;
	logic  pop;
	logic  not_empty;
	logic  full;
	snap_t head;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	nntp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_char    (s_tdata),
		.char_present (s_tuser),
		.end_of_text  (s_tlast),
		.push         (push),
		.push_snap    (push_snap)
	);

	nntp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_snap (push_snap),
		.pop       (pop),
		.not_empty (not_empty),
		.full      (full),
		.head      (head)
	);

	nntp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.snap_valid (not_empty),
		.snap       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
